>>> src/jrsp_pkg.sv
// Shared types and constants for the joystick rate servo positioner.
// No dependencies; imported by jrsp_div and joystick_rate_servo_positioner.
`default_nettype none

package jrsp_pkg;

    // Geometry
    localparam int NUM_AXES     = 2;
    localparam int CAL_SAMPLES  = 10;
    localparam int AXIS_W       = 1;
    localparam int SAMPLE_W     = 10;
    localparam int ANGLE_W      = 8;
    localparam int DZ_W         = 9;
    localparam int STEP_W       = 4;
    localparam int SUM_W        = 14;
    localparam int CNT_W        = $clog2(CAL_SAMPLES + 1);
    localparam int AXIS_CNT_W   = $clog2(NUM_AXES + 1);

    // Shared divider sizes
    localparam int DVD_W        = SUM_W;
    localparam int DVS_W        = SAMPLE_W;
    localparam int DIV_CNT_W    = $clog2(DVD_W);

    // Fixed values
    localparam int SAMPLE_FULL  = 1023;
    localparam int RESET_ANGLE  = 90;

    // Configuration port
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = DZ_W;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MAX = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP  = 2'd3;

    // Stream widths
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MOVE,
        ST_OUT
    } state_t;

    // Request into the shared divider
    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
    } div_req_t;

    // Response from the shared divider
    typedef struct packed {
        logic               done;
        logic [DVD_W-1:0]   quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> src/jrsp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on jrsp_pkg for widths and the request/response structs.
`default_nettype none

module jrsp_div (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  jrsp_pkg::div_req_t  req,
    output jrsp_pkg::div_rsp_t  rsp
);
    import jrsp_pkg::*;

    logic                   busy_reg;
    logic                   done_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DVD_W-1:0]       dvd_reg;
    logic [DVS_W-1:0]       dvs_reg;
    logic [DVS_W:0]         rem_reg;

    logic [DVS_W:0]         rem_shift;
    logic                   q_bit;
    logic [DVS_W:0]         rem_new;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_shift = {rem_reg[DVS_W-1:0], dvd_reg[DVD_W-1]};
        q_bit     = (rem_shift >= {1'b0, dvs_reg});
        rem_new   = q_bit ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(DVD_W - 1));
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: quotient bits shift into the dividend register
    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], q_bit};
            rem_reg <= rem_new;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

`default_nettype wire

>>> src/joystick_rate_servo_positioner.sv
// Joystick rate servo positioner: top level, sequencer and per-axis state.
// Depends on jrsp_pkg and jrsp_div.
//
// Each input transaction carries one joystick reading for one axis, tagged in
// s_tuser as calibration (0) or control (1). Calibration readings are summed
// per axis; every CAL_SAMPLES-th one sets the axis center to the truncated
// average. A control reading outside center +/- deadzone is scaled to a step
// of up to max_step degrees, which moves that axis's servo angle within
// [angle_min, angle_max]. Every input gives exactly one output transaction
// with the axis, its angle and a moved flag. The block handles one item at a
// time: a calibration reading that does not close a run, or a control reading
// inside the neutral band, goes from acceptance through the preparation and
// output states to the result register; a reading that needs a division also
// waits in the division state on the single shared divider, which produces one
// quotient bit per cycle over 14 bits, and a control reading then passes a
// move state before the output state. A new input is accepted once the
// previous item has reached the result register, even if that result has not
// been taken yet. Configuration writes take effect at once and are meant to be
// made while the block is idle.
`default_nettype none

module joystick_rate_servo_positioner (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // Configuration
    input  wire                                  cfg_wr_en,
    input  wire  [jrsp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [jrsp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // Input stream
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [jrsp_pkg::S_TDATA_W-1:0]       s_tdata,  // [0] axis, [10:1] sample
    input  wire                                  s_tuser,  // [0] req_type
    // Result stream
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [jrsp_pkg::M_TDATA_W-1:0]       m_tdata   // [0] servo_index,
                                                           // [8:1] servo_angle, [9] moved
);
    import jrsp_pkg::*;

    // Configuration registers
    logic [DZ_W-1:0]        deadzone_reg;
    logic [ANGLE_W-1:0]     angle_min_reg;
    logic [ANGLE_W-1:0]     angle_max_reg;
    logic [STEP_W-1:0]      max_step_reg;

    // Per-axis state
    logic [SAMPLE_W-1:0]    center_reg [NUM_AXES];
    logic [SUM_W-1:0]       sum_reg    [NUM_AXES];
    logic [CNT_W-1:0]       count_reg  [NUM_AXES];
    logic [ANGLE_W-1:0]     pos_reg    [NUM_AXES];

    // Sequencer
    state_t                 state_reg, state_next;

    // Latched item
    logic                   type_reg;
    logic [AXIS_W-1:0]      axis_reg;
    logic [SAMPLE_W-1:0]    sample_reg;
    logic                   below_reg;
    logic signed [5:0]      step_reg;
    logic                   moved_reg;

    // Result register
    logic                   m_valid_reg;
    logic [M_TDATA_W-1:0]   m_data_reg;

    div_req_t               div_req;
    div_rsp_t               div_rsp;

    // Working signals
    logic                   axis_ok;
    logic [SAMPLE_W-1:0]    center;
    logic [ANGLE_W-1:0]     pos;
    logic [SUM_W-1:0]       sum_new;
    logic [CNT_W:0]         cnt_new;
    logic                   cal_full;
    logic signed [11:0]     lo;
    logic [11:0]            hi;
    logic                   is_below;
    logic                   is_above;
    logic [11:0]            hi_span;
    logic [SAMPLE_W-1:0]    scale_in;
    logic [SUM_W-1:0]       product;
    logic signed [5:0]      step_calc;
    logic signed [9:0]      target;
    logic signed [9:0]      mn_s;
    logic signed [9:0]      mx_s;
    logic                   step_neg;
    logic                   blocked;
    logic [ANGLE_W-1:0]     pos_new;
    logic                   out_free;

    jrsp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Per-item lookups and arithmetic
    always_comb begin
        axis_ok  = (AXIS_CNT_W'(axis_reg) < AXIS_CNT_W'(NUM_AXES));
        center   = center_reg[axis_reg];
        pos      = pos_reg[axis_reg];

        // Calibration accumulate
        sum_new  = sum_reg[axis_reg] + SUM_W'(sample_reg);
        cnt_new  = {1'b0, count_reg[axis_reg]} + 1'b1;
        cal_full = (cnt_new >= (CNT_W + 1)'(CAL_SAMPLES));

        // Neutral band bounds
        lo       = $signed({2'b00, center}) - $signed({3'b000, deadzone_reg});
        hi       = {2'b00, center} + {3'b000, deadzone_reg};
        is_below = $signed({2'b00, sample_reg}) < lo;
        is_above = {2'b00, sample_reg} > hi;
        hi_span  = 12'(SAMPLE_FULL) - hi;

        // Below the band the reading itself is scaled, above it the distance
        // past the upper edge (hi is below 1023 there, so it fits 10 bits)
        scale_in = is_below ? sample_reg : (sample_reg - hi[SAMPLE_W-1:0]);
        product  = SUM_W'(scale_in) * SUM_W'(max_step_reg);

        // Step from quotient (quotient never exceeds max_step)
        step_calc = below_reg
                  ? ($signed({1'b0, div_rsp.quotient[4:0]}) - $signed({2'b00, max_step_reg}))
                  : $signed({1'b0, div_rsp.quotient[4:0]});

        // Move and clamp
        target   = $signed({2'b00, pos}) + 10'(step_reg);
        mn_s     = $signed({2'b00, angle_min_reg});
        mx_s     = $signed({2'b00, angle_max_reg});
        step_neg = step_reg < 0;
        blocked  = (step_reg == 0)
                || ((pos <= angle_min_reg) && step_neg)
                || ((pos >= angle_max_reg) && !step_neg);
        if (target <= mn_s) begin
            pos_new = angle_min_reg;
        end else if (target >= mx_s) begin
            pos_new = angle_max_reg;
        end else begin
            pos_new = target[ANGLE_W-1:0];
        end

        out_free = !m_valid_reg || m_tready;
    end

    // Next state and divider request
    always_comb begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = type_reg ? product : sum_new;
        div_req.divisor  = !type_reg ? DVS_W'(CAL_SAMPLES)
                         : (is_below ? lo[DVS_W-1:0] : hi_span[DVS_W-1:0]);
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (!axis_ok) begin
                    state_next = ST_OUT;
                end else if (!type_reg) begin
                    if (cal_full) begin
                        div_req.start = 1'b1;
                        state_next    = ST_DIV;
                    end else begin
                        state_next = ST_OUT;
                    end
                end else if (is_below || is_above) begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = type_reg ? ST_MOVE : ST_OUT;
                end
            end
            ST_MOVE: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadzone_reg  <= DZ_W'(40);
            angle_min_reg <= ANGLE_W'(1);
            angle_max_reg <= ANGLE_W'(170);
            max_step_reg  <= STEP_W'(5);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DEADZONE:  deadzone_reg  <= cfg_wdata;
                CFG_ANGLE_MIN: angle_min_reg <= cfg_wdata[ANGLE_W-1:0];
                CFG_ANGLE_MAX: angle_max_reg <= cfg_wdata[ANGLE_W-1:0];
                CFG_MAX_STEP:  max_step_reg  <= cfg_wdata[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Per-axis state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                center_reg[i] <= '0;
                sum_reg[i]    <= '0;
                count_reg[i]  <= '0;
                pos_reg[i]    <= ANGLE_W'(RESET_ANGLE);
            end
        end else begin
            if (state_reg == ST_PREP && axis_ok && !type_reg) begin
                if (cal_full) begin
                    sum_reg[axis_reg]   <= '0;
                    count_reg[axis_reg] <= '0;
                end else begin
                    sum_reg[axis_reg]   <= sum_new;
                    count_reg[axis_reg] <= cnt_new[CNT_W-1:0];
                end
            end
            if (state_reg == ST_DIV && div_rsp.done && !type_reg) begin
                center_reg[axis_reg] <= div_rsp.quotient[SAMPLE_W-1:0];
            end
            if (state_reg == ST_MOVE && !blocked) begin
                pos_reg[axis_reg] <= pos_new;
            end
        end
    end

    // Item latch and step bookkeeping
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            type_reg   <= s_tuser;
            axis_reg   <= s_tdata[AXIS_W-1:0];
            sample_reg <= s_tdata[AXIS_W +: SAMPLE_W];
        end
        if (state_reg == ST_PREP) begin
            below_reg <= is_below;
            moved_reg <= 1'b0;
        end
        if (state_reg == ST_DIV && div_rsp.done) begin
            step_reg <= step_calc;
        end
        if (state_reg == ST_MOVE) begin
            moved_reg <= !blocked;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_data_reg <= M_TDATA_W'({moved_reg && axis_ok,
                                      axis_ok ? pos : ANGLE_W'(0),
                                      axis_reg});
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Checks
    a_accept_to_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_PREP))
        else $error("accepted item did not enter preparation");

    a_div_start_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> (state_reg == ST_PREP))
        else $error("divider started outside preparation");

    a_div_leave: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && div_rsp.done) |=> (state_reg != ST_DIV))
        else $error("sequencer stuck after divider finished");

    a_center_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (center_reg[0] != $past(center_reg[0])) |-> $past(state_reg == ST_DIV))
        else $error("axis center changed without a division");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("result not loaded on leaving output state");

endmodule

`default_nettype wire

>>> tb/sv/joystick_rate_servo_positioner_test.sv
// Self-checking testbench for joystick_rate_servo_positioner: directed and random
// joystick readings against an in-bench model of the per-axis positioner.
// Depends on jrsp_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module joystick_rate_servo_positioner_test;
    import jrsp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 40;     // well past the longest item
    localparam int MAX_REPORTS  = 10;

    // One result transaction as seen on m_tdata
    typedef struct packed {
        logic               idx;
        logic [ANGLE_W-1:0] angle;
        logic               moved;
    } servo_report_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_W-1:0]     s_tdata   = '0;  // [0] axis, [10:1] sample
    logic                     s_tuser   = 1'b0; // [0] req_type
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]     m_tdata;          // [0] servo_index, [8:1] servo_angle, [9] moved

    joystick_rate_servo_positioner dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the block's registers and per-axis state
    logic [DZ_W-1:0]     dz_cfg;
    logic [ANGLE_W-1:0]  min_cfg;
    logic [ANGLE_W-1:0]  max_cfg;
    logic [STEP_W-1:0]   step_cfg;
    logic [SAMPLE_W-1:0] center_est [NUM_AXES];
    logic [SUM_W-1:0]    cal_sum    [NUM_AXES];
    logic [CNT_W-1:0]    cal_cnt    [NUM_AXES];
    logic [ANGLE_W-1:0]  pos_deg    [NUM_AXES];

    servo_report_t pending_reports [$];
    int            fail_count    = 0;
    int            cycle_count   = 0;

    // Stimulus shaping
    int ready_pct     = 100;
    int gap_max       = 0;
    int burst_max     = 16;
    int burst_left    = 0;
    int hold_request  = 0;
    int hold_left     = 0;

    // Step in degrees for a control reading against a center
    function automatic int rate_step(int v, int c);
        int lo, hi, ms;
        lo = c - int'(dz_cfg);
        hi = c + int'(dz_cfg);
        ms = int'(step_cfg);
        if (v < lo)
            return (v * ms) / lo - ms;
        if (v > hi)
            return ((v - hi) * ms) / (SAMPLE_FULL - hi);
        return 0;
    endfunction

    // Advance the shadow state by one accepted reading, return the expected report
    function automatic servo_report_t predict_report(logic ctrl, logic ax,
                                                     logic [SAMPLE_W-1:0] smp);
        servo_report_t r;
        int d, a, t, mn, mx;
        logic mv;
        mv = 1'b0;
        if (!ctrl) begin
            cal_sum[ax] = cal_sum[ax] + smp;
            cal_cnt[ax] = cal_cnt[ax] + 1'b1;
            if (cal_cnt[ax] >= CAL_SAMPLES) begin
                center_est[ax] = SAMPLE_W'(cal_sum[ax] / CAL_SAMPLES);
                cal_sum[ax]    = '0;
                cal_cnt[ax]    = '0;
            end
        end else begin
            d  = rate_step(int'(smp), int'(center_est[ax]));
            a  = int'(pos_deg[ax]);
            mn = int'(min_cfg);
            mx = int'(max_cfg);
            // limits are applied literally, even when crossed
            if (d != 0 && !((a <= mn && d < 0) || (a >= mx && d > 0))) begin
                t = a + d;
                if (t <= mn)
                    t = mn;
                else if (t >= mx)
                    t = mx;
                pos_deg[ax] = t[ANGLE_W-1:0];
                mv = 1'b1;
            end
        end
        r.idx   = ax;
        r.angle = pos_deg[ax];
        r.moved = mv;
        return r;
    endfunction

    // Reading biased toward the extremes and the edges of the neutral band
    function automatic logic [SAMPLE_W-1:0] pick_sample(logic ax);
        int v, band_edge;
        case ($urandom_range(3))
            1: v = $urandom_range(1) ? SAMPLE_FULL - int'($urandom_range(3))
                                     : int'($urandom_range(3));
            2: begin
                band_edge = $urandom_range(1) ? int'(center_est[ax]) + int'(dz_cfg)
                                              : int'(center_est[ax]) - int'(dz_cfg);
                v = band_edge + int'($urandom_range(4)) - 2;
            end
            default: v = $urandom_range(SAMPLE_FULL);
        endcase
        if (v < 0)
            v = 0;
        else if (v > SAMPLE_FULL)
            v = SAMPLE_FULL;
        return v[SAMPLE_W-1:0];
    endfunction

    // Offer one reading and wait for the input transaction
    task automatic send_reading(input logic ctrl, input logic ax,
                                input logic [SAMPLE_W-1:0] smp);
        if (burst_left == 0) begin
            if (gap_max > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat ($urandom_range(gap_max) ) @(negedge aclk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = ctrl;
        s_tdata  = {{(S_TDATA_W - SAMPLE_W - AXIS_W){1'b0}}, smp, ax};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_reports.push_back(predict_report(ctrl, ax, smp));
    endtask

    // Stop offering and wait until every expected report has arrived
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_DEADZONE:  dz_cfg   = value[DZ_W-1:0];
            CFG_ANGLE_MIN: min_cfg  = value[ANGLE_W-1:0];
            CFG_ANGLE_MAX: max_cfg  = value[ANGLE_W-1:0];
            CFG_MAX_STEP:  step_cfg = value[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int dz, input int mn, input int mx, input int ms);
        write_reg(CFG_DEADZONE, dz);
        write_reg(CFG_ANGLE_MIN, mn);
        write_reg(CFG_ANGLE_MAX, mx);
        write_reg(CFG_MAX_STEP, ms);
    endtask

    // Mostly control readings; some single calibration readings and whole runs
    task automatic random_readings(input int count);
        int sent, base, v;
        logic ax;
        sent = 0;
        while (sent < count) begin
            ax = 1'($urandom_range(1));
            if ($urandom_range(99) < 6) begin
                // full calibration run around one stick position
                base = $urandom_range(SAMPLE_FULL);
                for (int i = 0; i < CAL_SAMPLES; i++) begin
                    v = base + int'($urandom_range(40)) - 20;
                    if (v < 0)
                        v = 0;
                    else if (v > SAMPLE_FULL)
                        v = SAMPLE_FULL;
                    send_reading(1'b0, ax, v[SAMPLE_W-1:0]);
                end
                sent += CAL_SAMPLES;
            end else begin
                send_reading($urandom_range(99) >= 15, ax, pick_sample(ax));
                sent++;
            end
        end
    endtask

    // Uncalibrated axes: center 0, full deflection and the neutral band
    task automatic test_uncalibrated_axes();
        ready_pct = 80;
        gap_max   = 2;
        send_reading(1'b1, 1'b0, 10'd1023);
        send_reading(1'b1, 1'b1, 10'd0);
        send_reading(1'b1, 1'b0, 10'd40);
        send_reading(1'b1, 1'b0, 10'd41);
        send_reading(1'b0, 1'b1, 10'd512);
        send_reading(1'b1, 1'b1, 10'd1023);
        drain_results();
    endtask

    // One full calibration run, then both directions and the band edges
    task automatic test_calibration_run();
        for (int i = 0; i < CAL_SAMPLES; i++)
            send_reading(1'b0, 1'b0, (i % 2) ? 10'd1023 : 10'd0);
        send_reading(1'b1, 1'b0, 10'd0);
        send_reading(1'b1, 1'b0, 10'd1023);
        send_reading(1'b1, 1'b0, 10'd470);
        send_reading(1'b1, 1'b0, 10'd552);
        send_reading(1'b1, 1'b0, 10'd511);
        drain_results();
    endtask

    // Fixed register settings including the extremes and crossed limits
    task automatic test_limit_settings();
        int limits [7][4];
        limits = '{'{0, 0, 180, 15}, '{511, 0, 180, 1}, '{100, 45, 135, 8},
                   '{20, 150, 30, 7}, '{10, 10, 170, 0}, '{5, 90, 90, 3},
                   '{40, 1, 170, 5}};
        for (int k = 0; k < 7; k++) begin
            apply_settings(limits[k][0], limits[k][1], limits[k][2], limits[k][3]);
            ready_pct = (k % 3 == 0) ? 100 : (k % 3 == 1) ? 70 : 35;
            gap_max   = (k % 3 == 0) ? 0 : (k % 3 == 1) ? 3 : 8;
            random_readings(120);
            drain_results();
        end
    endtask

    // Long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        apply_settings(60, 0, 180, 9);
        ready_pct = 100;
        gap_max   = 0;
        @(posedge aclk);
        hold_request = 400;
        random_readings(40);
        drain_results();
    endtask

    // Random register values, random idling
    task automatic test_random_settings();
        for (int k = 0; k < 4; k++) begin
            apply_settings($urandom_range(511), $urandom_range(180),
                           $urandom_range(180), $urandom_range(15));
            ready_pct = $urandom_range(30, 100);
            gap_max   = $urandom_range(0, 6);
            random_readings(140);
            drain_results();
        end
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            m_tready  = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready = ($urandom_range(99) < ready_pct);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        servo_report_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.idx   = m_tdata[0];
            got.angle = m_tdata[ANGLE_W:1];
            got.moved = m_tdata[ANGLE_W+1];
            if (pending_reports.size() == 0) begin
                if (fail_count < MAX_REPORTS)
                    $display("unexpected result: idx %0d angle %0d moved %0d",
                             got.idx, got.angle, got.moved);
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                if (got.idx !== want.idx || got.angle !== want.angle ||
                    got.moved !== want.moved) begin
                    if (fail_count < MAX_REPORTS)
                        $display({"mismatch: expected idx %0d angle %0d moved %0d,",
                                  " got idx %0d angle %0d moved %0d"},
                                 want.idx, want.angle, want.moved,
                                 got.idx, got.angle, got.moved);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        dz_cfg   = 9'd40;
        min_cfg  = 8'd1;
        max_cfg  = 8'd170;
        step_cfg = 4'd5;
        for (int i = 0; i < NUM_AXES; i++) begin
            center_est[i] = '0;
            cal_sum[i]    = '0;
            cal_cnt[i]    = '0;
            pos_deg[i]    = ANGLE_W'(RESET_ANGLE);
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_uncalibrated_axes();
        test_calibration_run();
        test_limit_settings();
        test_backpressure();
        test_random_settings();
        drain_results();

        fail_count += pending_reports.size();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
